// ----- hw/rtl/tx_descriptor_ring_manager_core_assert.svh -----
// Assertion macros for the transmit descriptor ring
`ifndef TX_DESCRIPTOR_RING_MANAGER_CORE_ASSERT_SVH
`define TX_DESCRIPTOR_RING_MANAGER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define TXDR_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define TXDR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define TXDR_ASSERT(label, clk, rst, ante, cons)
`define TXDR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- hw/rtl/txdr_pkg.sv -----
package txdr_pkg;

  localparam int RING_ENTRIES = 16;
  localparam int IDX_W = $clog2(RING_ENTRIES);
  localparam int LIMIT_W = 5;
  localparam int CMP_W = (LIMIT_W > IDX_W) ? LIMIT_W : IDX_W;
  localparam int FRAME_W = 16;
  localparam int LEN_W = 13;
  localparam int ALIGN_W = 2;
  localparam int STATUS_W = 7;
  localparam int LEN_RAM_W = LEN_W + ALIGN_W;
  localparam logic [FRAME_W-1:0] MIN_FRAME = 16'd14;
  localparam logic [LEN_W-1:0] MAX_FRAME_RESET = 13'd4224;

  typedef enum logic [1:0] {
    OP_ENQUEUE  = 2'd0,
    OP_DMA_DONE = 2'd1,
    OP_RECLAIM  = 2'd2,
    OP_QUERY    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_BAD_LENGTH = 2'd1,
    ERR_RING_FULL  = 2'd2,
    ERR_NOT_OWNED  = 2'd3
  } err_t;

  typedef struct packed {
    logic             pkt_inc;
    logic [LEN_W-1:0] byte_add;
    logic [1:0]       err_add;
  } stats_cmd_t;

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] a);
    logic [IDX_W-1:0] r;
    if (a == IDX_W'(RING_ENTRIES - 1)) begin
      r = '0;
    end else begin
      r = a + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] ring_sub(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (a < b) begin
      d = d + (IDX_W + 1)'(RING_ENTRIES);
    end
    return d[IDX_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/txdr_ram.sv -----
module txdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/txdr_stats.sv -----
module txdr_stats (
  input  logic                 clk,
  input  logic                 rst,
  input  txdr_pkg::stats_cmd_t cmd,
  output logic [31:0]          packets,
  output logic [47:0]          bytes,
  output logic [31:0]          errors
);

  always_ff @(posedge clk) begin
    if (rst) begin
      packets <= '0;
      bytes   <= '0;
      errors  <= '0;
    end else begin
      packets <= packets + 32'(cmd.pkt_inc);
      bytes   <= bytes + 48'(cmd.byte_add);
      errors  <= errors + 32'(cmd.err_add);
    end
  end

endmodule

// ----- hw/rtl/tx_descriptor_ring_manager_core.sv -----
// Channel   Dir  Handshake            Payload
// s_axis    in   tvalid/tready        tuser: opcode; tdata: enqueue, status, limit fields
// m_axis    out  tvalid/tready        tdata: result flags, indexes, counters
// cfg       in   cfg_wr_en            cfg_wr_data: max_frame_length
//
// Enqueue, dma done and query register their result in the output register in the cycle after the item is taken.
// Reclaim walks the ring in S_WALK, one ring memory read per entry, before its result is registered.
// One item at a time; a new item is taken once the previous result has gone.
// Synchronous reset clears pointers, counters and the length limit to 4224.
// Ring memories carry no reset; each slot is written by enqueue before use.
`include "tx_descriptor_ring_manager_core_assert.svh"

module tx_descriptor_ring_manager_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [12:0]  cfg_wr_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [15:0] frame_length, [17:16] align_offset, [21:18] collision_count,
  // [22] excess_collisions, [23] underrun_flag, [24] late_collision_flag,
  // [29:25] reclaim_limit, [31:30] zero
  input  logic [31:0]  s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] accepted, [2:1] error_code, [6:3] entry_index, [10:7] free_space,
  // [15:11] reclaimed_count, [20:16] collisions_added, [21] underrun_seen,
  // [22] late_collision_seen, [23] kick_needed, [55:24] packets_sent,
  // [103:56] bytes_sent, [135:104] error_total
  output logic [135:0] m_axis_tdata
);

  localparam int IDX_W = txdr_pkg::IDX_W;
  localparam int CMP_W = txdr_pkg::CMP_W;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  state_t                           state;
  logic [IDX_W-1:0]                 head;
  logic [IDX_W-1:0]                 tail;
  logic [IDX_W-1:0]                 dma_pos;
  logic [txdr_pkg::LEN_W-1:0]       max_len;
  logic [CMP_W-1:0]                 remaining;
  logic                             rd_valid;
  logic [txdr_pkg::STATUS_W-1:0]    st_acc;
  logic                             res_accepted;
  txdr_pkg::err_t                   res_error;
  logic [IDX_W-1:0]                 res_index;
  logic [CMP_W-1:0]                 res_count;
  logic                             res_kick;
  logic                             res_accepted_next;
  txdr_pkg::err_t                   res_error_next;
  logic [IDX_W-1:0]                 res_index_next;
  logic [CMP_W-1:0]                 res_count_next;
  logic                             res_kick_next;

  logic                             in_fire;
  txdr_pkg::op_t                    in_op;
  logic [txdr_pkg::FRAME_W-1:0]     in_len;
  logic [txdr_pkg::ALIGN_W-1:0]     in_align;
  logic [txdr_pkg::STATUS_W-1:0]    in_status;
  logic [txdr_pkg::LIMIT_W-1:0]     in_limit;
  logic                             bad_len;
  logic                             full;
  logic                             no_owned;
  logic [IDX_W-1:0]                 space;
  logic [CMP_W-1:0]                 space_wide;
  logic [CMP_W-1:0]                 index_wide;
  logic                             kick;
  logic [CMP_W-1:0]                 avail_wide;
  logic [CMP_W-1:0]                 limit_wide;
  logic [CMP_W-1:0]                 walk_n;
  logic                             walk_done;
  logic                             len_we;
  logic                             dma_we;
  logic                             status_we;
  logic [IDX_W-1:0]                 status_waddr;
  logic [txdr_pkg::STATUS_W-1:0]    status_wdata;
  logic [txdr_pkg::LEN_RAM_W-1:0]   len_rdata;
  logic [txdr_pkg::STATUS_W-1:0]    status_rdata;
  txdr_pkg::stats_cmd_t             stats_cmd;
  logic [31:0]                      packets;
  logic [47:0]                      bytes;
  logic [31:0]                      errors;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign in_op     = txdr_pkg::op_t'(s_axis_tuser);
  assign in_len    = s_axis_tdata[15:0];
  assign in_align  = s_axis_tdata[17:16];
  assign in_status = s_axis_tdata[24:18];
  assign in_limit  = s_axis_tdata[29:25];

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;

  always_comb begin
    bad_len    = (in_len < txdr_pkg::MIN_FRAME) ||
                 (in_len > txdr_pkg::FRAME_W'(max_len));
    full       = (txdr_pkg::ring_inc(head) == tail);
    no_owned   = (dma_pos == head);
    space      = txdr_pkg::ring_sub(tail, head);
    space      = (space == '0) ? IDX_W'(txdr_pkg::RING_ENTRIES - 1) : space - 1'b1;
    space_wide = CMP_W'(space);
    index_wide = CMP_W'(res_index);
    kick       = (space == '0) && (tail != dma_pos);
    avail_wide = CMP_W'(txdr_pkg::ring_sub(dma_pos, tail));
    limit_wide = CMP_W'(in_limit);
    walk_n     = (limit_wide < avail_wide) ? limit_wide : avail_wide;
    walk_done  = (state == S_WALK) && (remaining == '0) && !rd_valid;
  end

  always_comb begin
    res_accepted_next = 1'b1;
    res_error_next    = txdr_pkg::ERR_NONE;
    res_index_next    = '0;
    res_count_next    = '0;
    res_kick_next     = 1'b0;
    unique case (in_op)
      txdr_pkg::OP_ENQUEUE: begin
        if (bad_len) begin
          res_accepted_next = 1'b0;
          res_error_next    = txdr_pkg::ERR_BAD_LENGTH;
        end else if (full) begin
          res_accepted_next = 1'b0;
          res_error_next    = txdr_pkg::ERR_RING_FULL;
        end else begin
          res_index_next = head;
        end
      end
      txdr_pkg::OP_DMA_DONE: begin
        if (no_owned) begin
          res_accepted_next = 1'b0;
          res_error_next    = txdr_pkg::ERR_NOT_OWNED;
        end else begin
          res_index_next = dma_pos;
        end
      end
      txdr_pkg::OP_RECLAIM: begin
        res_count_next = walk_n;
      end
      txdr_pkg::OP_QUERY: begin
        res_kick_next = kick;
      end
    endcase
  end

  always_comb begin
    len_we       = in_fire && (in_op == txdr_pkg::OP_ENQUEUE) && !bad_len && !full;
    dma_we       = in_fire && (in_op == txdr_pkg::OP_DMA_DONE) && !no_owned;
    status_we    = len_we || dma_we;
    status_waddr = dma_we ? dma_pos : head;
    status_wdata = dma_we ? in_status : '0;
  end

  always_comb begin
    stats_cmd.pkt_inc  = rd_valid;
    stats_cmd.byte_add = rd_valid ? len_rdata[txdr_pkg::LEN_W-1:0] : '0;
    stats_cmd.err_add  = '0;
    if (in_fire && (in_op == txdr_pkg::OP_ENQUEUE) && (bad_len || full)) begin
      stats_cmd.err_add = 2'd1;
    end else if (walk_done) begin
      stats_cmd.err_add = {1'b0, st_acc[5]} + {1'b0, st_acc[6]};
    end
  end

  txdr_ram #(
    .WIDTH (txdr_pkg::LEN_RAM_W),
    .DEPTH (txdr_pkg::RING_ENTRIES)
  ) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (head),
    .wdata ({in_align, in_len[txdr_pkg::LEN_W-1:0]}),
    .raddr (tail),
    .rdata (len_rdata)
  );

  txdr_ram #(
    .WIDTH (txdr_pkg::STATUS_W),
    .DEPTH (txdr_pkg::RING_ENTRIES)
  ) u_status_ram (
    .clk   (clk),
    .we    (status_we),
    .waddr (status_waddr),
    .wdata (status_wdata),
    .raddr (tail),
    .rdata (status_rdata)
  );

  txdr_stats u_stats (
    .clk     (clk),
    .rst     (rst),
    .cmd     (stats_cmd),
    .packets (packets),
    .bytes   (bytes),
    .errors  (errors)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head          <= '0;
      tail          <= '0;
      dma_pos       <= '0;
      max_len       <= txdr_pkg::MAX_FRAME_RESET;
      remaining     <= '0;
      rd_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_len <= cfg_wr_data;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            res_accepted <= res_accepted_next;
            res_error    <= res_error_next;
            res_index    <= res_index_next;
            res_count    <= res_count_next;
            res_kick     <= res_kick_next;
            st_acc       <= '0;
            unique case (in_op)
              txdr_pkg::OP_ENQUEUE: begin
                m_axis_tvalid <= 1'b1;
                if (!bad_len && !full) begin
                  head <= txdr_pkg::ring_inc(head);
                end
              end
              txdr_pkg::OP_DMA_DONE: begin
                m_axis_tvalid <= 1'b1;
                if (!no_owned) begin
                  dma_pos <= txdr_pkg::ring_inc(dma_pos);
                end
              end
              txdr_pkg::OP_RECLAIM: begin
                remaining <= walk_n;
                state     <= S_WALK;
              end
              txdr_pkg::OP_QUERY: begin
                m_axis_tvalid <= 1'b1;
              end
            endcase
          end
        end
        S_WALK: begin
          rd_valid <= (remaining != '0);
          if (remaining != '0) begin
            tail      <= txdr_pkg::ring_inc(tail);
            remaining <= remaining - 1'b1;
          end
          if (rd_valid) begin
            st_acc <= st_acc | status_rdata;
          end
          if (walk_done) begin
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign m_axis_tdata = {errors, bytes, packets, res_kick, st_acc[6], st_acc[5],
                         st_acc[4:0], res_count[4:0], space_wide[3:0],
                         index_wide[3:0], res_error, res_accepted};

  `TXDR_ASSERT(a_walk_before_dma, clk, rst, (state == S_WALK) && (remaining != '0), tail != dma_pos)
  `TXDR_ASSERT(a_dma_in_ring, clk, rst, 1'b1, txdr_pkg::ring_sub(dma_pos, tail) <= txdr_pkg::ring_sub(head, tail))
  `TXDR_ASSERT_NEXT(a_walk_result, clk, rst, walk_done, m_axis_tvalid && (state == S_IDLE))
  `TXDR_ASSERT_NEXT(a_reclaim_walks, clk, rst, in_fire && (in_op == txdr_pkg::OP_RECLAIM), (state == S_WALK) && !m_axis_tvalid)

endmodule
